[hdl/source_text_tokenizer_core_defines.svh]
// ----------------------------------------------------------------------------
// Tokenizer assertion macros
// Shared assertion shorthands; every use samples on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_CORE_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define STT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// Tokenizer package
// Token kind codes, character codes and the word types shared by the blocks.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Token kinds
  localparam logic [3:0] KIND_ID      = 4'd0;
  localparam logic [3:0] KIND_INT     = 4'd1;
  localparam logic [3:0] KIND_FLOAT   = 4'd2;
  localparam logic [3:0] KIND_STRING  = 4'd3;
  localparam logic [3:0] KIND_EQ      = 4'd4;
  localparam logic [3:0] KIND_SEMI    = 4'd5;
  localparam logic [3:0] KIND_LPAREN  = 4'd6;
  localparam logic [3:0] KIND_RPAREN  = 4'd7;
  localparam logic [3:0] KIND_LBRACE  = 4'd8;
  localparam logic [3:0] KIND_RBRACE  = 4'd9;
  localparam logic [3:0] KIND_COMMA   = 4'd10;
  localparam logic [3:0] KIND_EOF     = 4'd11;
  localparam logic [3:0] KIND_UNKNOWN = 4'd12;
  localparam logic [3:0] KIND_UNTERM  = 4'd13;

  // Character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  // Position counters saturate here
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  // Queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One result word
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  chr;
    logic        has;
    logic        first;
    logic        last;
    logic [15:0] line;
    logic [15:0] col;
  } item_t;

  // All words caused by one input byte: one or two
  typedef struct packed {
    item_t a;
    item_t b;
    logic  two;
  } entry_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

[hdl/stt_if.sv]
// ----------------------------------------------------------------------------
// Tokenizer channel interfaces
// Text byte channel and token word channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stt_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface stt_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [7:0]  token_char;
  logic        has_char;
  logic        token_first;
  logic        token_last;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic        run_end;

  modport source (output valid, output token_kind, output token_char, output has_char,
                  output token_first, output token_last, output start_line,
                  output start_column, output run_end, input ready);
  modport sink   (input valid, input token_kind, input token_char, input has_char,
                  input token_first, input token_last, input start_line,
                  input start_column, input run_end, output ready);
endinterface

[hdl/stt_front.sv]
// ----------------------------------------------------------------------------
// Tokenizer front end
// Classifies each byte, runs the scan mode and packs the words it causes.
// ----------------------------------------------------------------------------
module stt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         char_code_i,
  input  logic               end_of_text_i,
  output logic               push_o,
  output stt_pkg::entry_t    entry_o
);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_INT    = 3'd2,
    MODE_FRAC   = 3'd3,
    MODE_STRING = 3'd4,
    MODE_DONE   = 3'd5
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [7:0]  held_char_q, held_char_d;
  logic        held_valid_q, held_valid_d;
  logic        held_first_q, held_first_d;
  logic [15:0] line_q, line_d;
  logic [15:0] col_q, col_d;
  logic [15:0] tok_line_q, tok_line_d;
  logic [15:0] tok_col_q, tok_col_d;

  stt_pkg::item_t e0, e1;
  logic           v0, v1;

  function automatic stt_pkg::item_t mk_item(logic [3:0] kind, logic [7:0] chr, logic has,
                                             logic first, logic last, logic [15:0] line,
                                             logic [15:0] col);
    stt_pkg::item_t it;
    it.kind  = kind;
    it.chr   = has ? chr : stt_pkg::CH_NUL;
    it.has   = has;
    it.first = first;
    it.last  = last;
    it.line  = line;
    it.col   = col;
    return it;
  endfunction

  // Classify the byte
  logic is_letter, is_digit, is_alnum, is_end, is_blank, is_punct;
  logic [3:0] punct_kind;

  assign is_letter = ((char_code_i >= 8'h41) && (char_code_i <= 8'h5A)) ||
                     ((char_code_i >= 8'h61) && (char_code_i <= 8'h7A));
  assign is_digit  = (char_code_i >= 8'h30) && (char_code_i <= 8'h39);
  assign is_alnum  = is_letter || is_digit;
  assign is_end    = end_of_text_i || (char_code_i == stt_pkg::CH_NUL);
  assign is_blank  = (char_code_i == stt_pkg::CH_SPACE) || (char_code_i == stt_pkg::CH_LF);

  always_comb begin
    is_punct   = 1'b1;
    punct_kind = stt_pkg::KIND_UNKNOWN;
    unique case (char_code_i)
      stt_pkg::CH_EQ:     punct_kind = stt_pkg::KIND_EQ;
      stt_pkg::CH_SEMI:   punct_kind = stt_pkg::KIND_SEMI;
      stt_pkg::CH_LPAREN: punct_kind = stt_pkg::KIND_LPAREN;
      stt_pkg::CH_RPAREN: punct_kind = stt_pkg::KIND_RPAREN;
      stt_pkg::CH_LBRACE: punct_kind = stt_pkg::KIND_LBRACE;
      stt_pkg::CH_RBRACE: punct_kind = stt_pkg::KIND_RBRACE;
      stt_pkg::CH_COMMA:  punct_kind = stt_pkg::KIND_COMMA;
      default:            is_punct   = 1'b0;
    endcase
  end

  // Scan mode and word generation
  always_comb begin
    logic        go_idle;
    logic        advance;
    logic [3:0]  held_kind;
    mode_d       = mode_q;
    held_char_d  = held_char_q;
    held_valid_d = held_valid_q;
    held_first_d = held_first_q;
    tok_line_d   = tok_line_q;
    tok_col_d    = tok_col_q;
    e0           = '0;
    e1           = '0;
    v0           = 1'b0;
    v1           = 1'b0;
    go_idle      = 1'b0;
    advance      = 1'b0;
    held_kind    = stt_pkg::KIND_ID;

    if (mode_q == MODE_DONE) begin
      // drop everything after end of text
    end else if (is_end) begin
      // close the open token, then eof
      if (mode_q == MODE_IDENT || mode_q == MODE_INT || mode_q == MODE_FRAC) begin
        held_kind = (mode_q == MODE_IDENT) ? stt_pkg::KIND_ID :
                    (mode_q == MODE_INT)   ? stt_pkg::KIND_INT : stt_pkg::KIND_FLOAT;
        v0 = held_valid_q;
        e0 = mk_item(held_kind, held_char_q, 1'b1, held_first_q, 1'b1, tok_line_q, tok_col_q);
      end else if (mode_q == MODE_STRING) begin
        v0 = 1'b1;
        e0 = mk_item(stt_pkg::KIND_UNTERM, held_char_q, held_valid_q,
                     held_valid_q ? held_first_q : 1'b1, 1'b1, tok_line_q, tok_col_q);
      end
      v1           = 1'b1;
      e1           = mk_item(stt_pkg::KIND_EOF, stt_pkg::CH_NUL, 1'b0, 1'b1, 1'b1,
                             line_q, col_q);
      mode_d       = MODE_DONE;
      held_valid_d = 1'b0;
      held_first_d = 1'b0;
      held_char_d  = stt_pkg::CH_NUL;
    end else begin
      unique case (mode_q)
        MODE_IDENT: begin
          v0 = 1'b1;
          if (is_alnum) begin
            e0           = mk_item(stt_pkg::KIND_ID, held_char_q, 1'b1, held_first_q, 1'b0,
                                   tok_line_q, tok_col_q);
            held_char_d  = char_code_i;
            held_first_d = 1'b0;
            advance      = 1'b1;
          end else begin
            e0      = mk_item(stt_pkg::KIND_ID, held_char_q, 1'b1, held_first_q, 1'b1,
                              tok_line_q, tok_col_q);
            go_idle = 1'b1;
          end
        end
        MODE_INT: begin
          v0 = 1'b1;
          if (is_digit || (char_code_i == stt_pkg::CH_DOT)) begin
            held_kind    = (char_code_i == stt_pkg::CH_DOT) ? stt_pkg::KIND_FLOAT
                                                            : stt_pkg::KIND_INT;
            mode_d       = (char_code_i == stt_pkg::CH_DOT) ? MODE_FRAC : MODE_INT;
            e0           = mk_item(held_kind, held_char_q, 1'b1, held_first_q, 1'b0,
                                   tok_line_q, tok_col_q);
            held_char_d  = char_code_i;
            held_first_d = 1'b0;
            advance      = 1'b1;
          end else begin
            e0      = mk_item(stt_pkg::KIND_INT, held_char_q, 1'b1, held_first_q, 1'b1,
                              tok_line_q, tok_col_q);
            go_idle = 1'b1;
          end
        end
        MODE_FRAC: begin
          v0 = 1'b1;
          if (is_digit) begin
            e0           = mk_item(stt_pkg::KIND_FLOAT, held_char_q, 1'b1, held_first_q,
                                   1'b0, tok_line_q, tok_col_q);
            held_char_d  = char_code_i;
            held_first_d = 1'b0;
            advance      = 1'b1;
          end else begin
            e0      = mk_item(stt_pkg::KIND_FLOAT, held_char_q, 1'b1, held_first_q, 1'b1,
                              tok_line_q, tok_col_q);
            go_idle = 1'b1;
          end
        end
        MODE_STRING: begin
          advance = 1'b1;
          if (char_code_i == stt_pkg::CH_QUOTE) begin
            // close quote: last character, or an empty string
            v0           = 1'b1;
            e0           = mk_item(stt_pkg::KIND_STRING, held_char_q, held_valid_q,
                                   held_valid_q ? held_first_q : 1'b1, 1'b1,
                                   tok_line_q, tok_col_q);
            mode_d       = MODE_IDLE;
            held_valid_d = 1'b0;
          end else begin
            v0           = held_valid_q;
            e0           = mk_item(stt_pkg::KIND_STRING, held_char_q, 1'b1, held_first_q,
                                   1'b0, tok_line_q, tok_col_q);
            held_char_d  = char_code_i;
            held_valid_d = 1'b1;
            held_first_d = !held_valid_q;
          end
        end
        default: go_idle = 1'b1;
      endcase

      // Start a new token or skip the byte
      if (go_idle) begin
        advance      = 1'b1;
        held_valid_d = 1'b0;
        mode_d       = MODE_IDLE;
        if (is_blank) begin
          // skip
        end else if (is_alnum) begin
          mode_d       = is_letter ? MODE_IDENT : MODE_INT;
          tok_line_d   = line_q;
          tok_col_d    = col_q;
          held_char_d  = char_code_i;
          held_valid_d = 1'b1;
          held_first_d = 1'b1;
        end else if (char_code_i == stt_pkg::CH_QUOTE) begin
          mode_d       = MODE_STRING;
          tok_line_d   = line_q;
          tok_col_d    = col_q;
          held_first_d = 1'b0;
        end else begin
          v1 = 1'b1;
          e1 = mk_item(is_punct ? punct_kind : stt_pkg::KIND_UNKNOWN, char_code_i, 1'b1,
                       1'b1, 1'b1, line_q, col_q);
        end
      end
    end

    // Advance the saturating position
    line_d = line_q;
    col_d  = col_q;
    if (advance) begin
      if (char_code_i == stt_pkg::CH_LF) begin
        if (line_q != stt_pkg::POS_MAX) begin
          line_d = line_q + 16'd1;
        end
        col_d = 16'd1;
      end else if (col_q != stt_pkg::POS_MAX) begin
        col_d = col_q + 16'd1;
      end
    end
  end

  // Pack the words: earlier word always in slot a
  assign push_o      = accept_i && (v0 || v1);
  assign entry_o.a   = v0 ? e0 : e1;
  assign entry_o.b   = e1;
  assign entry_o.two = v0 && v1;

  // Hold scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      held_char_q  <= stt_pkg::CH_NUL;
      held_valid_q <= 1'b0;
      held_first_q <= 1'b0;
      line_q       <= 16'd1;
      col_q        <= 16'd1;
      tok_line_q   <= 16'd1;
      tok_col_q    <= 16'd1;
    end else if (accept_i) begin
      mode_q       <= mode_d;
      held_char_q  <= held_char_d;
      held_valid_q <= held_valid_d;
      held_first_q <= held_first_d;
      line_q       <= line_d;
      col_q        <= col_d;
      tok_line_q   <= tok_line_d;
      tok_col_q    <= tok_col_d;
    end
  end

endmodule

[hdl/stt_fifo.sv]
// ----------------------------------------------------------------------------
// Tokenizer word queue
// Short queue of packed entries between the front and back ends.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_core_defines.svh"

module stt_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stt_pkg::entry_t entry_i,
  input  logic            pop_i,
  output logic            full_o,
  output stt_pkg::head_t  head_o
);

  stt_pkg::entry_t                  mem_q [stt_pkg::QDEPTH];
  logic [stt_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [stt_pkg::QCNT_W-1:0]       count_q;

  assign full_o       = (count_q == stt_pkg::QCNT_W'(stt_pkg::QDEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `STT_ASSERT_NOW(a_no_overflow, push_i, !full_o, "push into full queue")
  `STT_ASSERT_NOW(a_no_underflow, pop_i, head_o.valid, "pop from empty queue")

endmodule

[hdl/stt_back.sv]
// ----------------------------------------------------------------------------
// Tokenizer back end
// Splits queue entries into single words and drives the output register.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_core_defines.svh"

module stt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stt_pkg::head_t head_i,
  output logic           pop_o,
  stt_token_if.source    token_o
);

  logic           sel_q;
  logic           out_valid_q;
  stt_pkg::item_t out_item_q;
  logic           run_end_q;
  logic           load;
  logic           last_of_entry;

  // Load a word when the output register is free or being taken
  assign load          = head_i.valid && (!out_valid_q || token_o.ready);
  assign last_of_entry = sel_q || !head_i.entry.two;
  assign pop_o         = load && last_of_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        sel_q       <= !last_of_entry;
        out_valid_q <= 1'b1;
      end else if (token_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q <= sel_q ? head_i.entry.b : head_i.entry.a;
      run_end_q  <= last_of_entry;
    end
  end

  assign token_o.valid        = out_valid_q;
  assign token_o.token_kind   = out_item_q.kind;
  assign token_o.token_char   = out_item_q.chr;
  assign token_o.has_char     = out_item_q.has;
  assign token_o.token_first  = out_item_q.first;
  assign token_o.token_last   = out_item_q.last;
  assign token_o.start_line   = out_item_q.line;
  assign token_o.start_column = out_item_q.col;
  assign token_o.run_end      = run_end_q;

  `STT_ASSERT_NXT(a_second_word_next, load && !sel_q && head_i.entry.two, sel_q,
                  "second word of a pair not selected")
  `STT_ASSERT_NOW(a_sel_needs_pair, sel_q, head_i.valid && head_i.entry.two,
                  "second-word select without a paired entry")

endmodule

[hdl/source_text_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// Source text tokenizer core
// Byte-serial lexer: front end scans, queue decouples, back end emits words.
//
//   channel   dir   payload                                   handshake
//   text_i    in    char_code, end_of_text                    valid/ready
//   token_o   out   kind, char, has_char, first, last,        valid/ready
//                   start_line, start_column, run_end
//
// One byte accepted per cycle while the queue has room; each byte is scanned
// in the cycle it is accepted and its one or two words enter the queue.
// Words leave at one per cycle while token_o is ready, so a byte that causes
// two words sends them out one after the other; each word passes the
// queue write and then the output register on its way to token_o.
// Reset clears the scan state, queue and output register at once.
// A stalled output fills the queue, then drops text_i.ready.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  stt_text_if.sink   text_i,
  stt_token_if.source token_o
);

  logic            push;
  logic            pop;
  logic            full;
  stt_pkg::entry_t entry;
  stt_pkg::head_t  head;

  assign text_i.ready = !full;

  stt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (text_i.valid && !full),
    .char_code_i   (text_i.char_code),
    .end_of_text_i (text_i.end_of_text),
    .push_o        (push),
    .entry_o       (entry)
  );

  stt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .head_o  (head)
  );

  stt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .pop_o   (pop),
    .token_o (token_o)
  );

endmodule

[sim/token_stream_checker.sv]
// ----------------------------------------------------------------------------
// Token stream checker
// Watches the text and token channels of the tokenizer core. Each accepted
// text byte is run through a local scanner that predicts the token words it
// causes; each accepted token word is compared field by field with the
// oldest prediction. Mismatches and unexpected words are counted.
// ----------------------------------------------------------------------------
module token_stream_checker
  import stt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  stt_text_if   text_mon,
  stt_token_if  token_mon,
  output int    fail_count_o,
  output int    words_pending_o
);

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_INT,
    SCAN_FRAC,
    SCAN_STRING,
    SCAN_DONE
  } scan_mode_t;

  // One predicted word: token fields plus the end-of-run flag
  typedef struct packed {
    item_t body;
    logic  run_end;
  } token_word_t;

  token_word_t expected_words[$];

  // Scanner state
  scan_mode_t  mode;
  logic [7:0]  held_char;
  logic        held_valid;
  logic        held_first;
  logic [15:0] line_no;
  logic [15:0] col_no;
  logic [15:0] tok_line;
  logic [15:0] tok_col;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Kind of a one-byte token; anything outside the punctuation set is unknown
  function automatic logic [3:0] single_kind(logic [7:0] c);
    case (c)
      CH_EQ:     return KIND_EQ;
      CH_SEMI:   return KIND_SEMI;
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      CH_LBRACE: return KIND_LBRACE;
      CH_RBRACE: return KIND_RBRACE;
      CH_COMMA:  return KIND_COMMA;
      default:   return KIND_UNKNOWN;
    endcase
  endfunction

  task automatic push_word(logic [3:0] kind, logic [7:0] chr, logic has, logic first,
                           logic last, logic [15:0] ln, logic [15:0] col);
    token_word_t w;
    w.body.kind  = kind;
    w.body.chr   = has ? chr : 8'h00;
    w.body.has   = has;
    w.body.first = first;
    w.body.last  = last;
    w.body.line  = ln;
    w.body.col   = col;
    w.run_end    = 1'b0;
    expected_words.push_back(w);
  endtask

  task automatic push_held(logic [3:0] kind, logic last);
    push_word(kind, held_char, 1'b1, held_first, last, tok_line, tok_col);
  endtask

  task automatic hold_char(logic [7:0] c, logic first);
    held_char  = c;
    held_valid = 1'b1;
    held_first = first;
  endtask

  // Newline bumps the line and rewinds the column; both saturate
  task automatic advance_position(logic [7:0] c);
    if (c == CH_LF) begin
      if (line_no != POS_MAX) line_no++;
      col_no = 16'd1;
    end else if (col_no != POS_MAX) begin
      col_no++;
    end
  endtask

  // Predict the words caused by one text byte
  task automatic scan_byte(logic [7:0] c, logic eot);
    int unsigned base;
    logic [15:0] ln;
    logic [15:0] col;
    logic        restart;
    logic        first;
    base    = expected_words.size();
    ln      = line_no;
    col     = col_no;
    restart = 1'b1;
    if (mode == SCAN_DONE) begin
      // input over: ignore everything
    end else if (eot || c == CH_NUL) begin
      // close the open token, then the end-of-file word
      case (mode)
        SCAN_IDENT: if (held_valid) push_held(KIND_ID, 1'b1);
        SCAN_INT:   if (held_valid) push_held(KIND_INT, 1'b1);
        SCAN_FRAC:  if (held_valid) push_held(KIND_FLOAT, 1'b1);
        SCAN_STRING: begin
          if (held_valid) push_held(KIND_UNTERM, 1'b1);
          else push_word(KIND_UNTERM, 8'h00, 1'b0, 1'b1, 1'b1, tok_line, tok_col);
        end
        default: ;
      endcase
      push_word(KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b1, ln, col);
      mode       = SCAN_DONE;
      held_valid = 1'b0;
      held_first = 1'b0;
      held_char  = 8'h00;
    end else begin
      // extend or close the open token
      case (mode)
        SCAN_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            push_held(KIND_ID, 1'b0);
            hold_char(c, 1'b0);
            restart = 1'b0;
          end else begin
            push_held(KIND_ID, 1'b1);
          end
        end
        SCAN_INT: begin
          if (is_digit(c) || c == CH_DOT) begin
            if (c == CH_DOT) mode = SCAN_FRAC;
            push_held((c == CH_DOT) ? KIND_FLOAT : KIND_INT, 1'b0);
            hold_char(c, 1'b0);
            restart = 1'b0;
          end else begin
            push_held(KIND_INT, 1'b1);
          end
        end
        SCAN_FRAC: begin
          if (is_digit(c)) begin
            push_held(KIND_FLOAT, 1'b0);
            hold_char(c, 1'b0);
            restart = 1'b0;
          end else begin
            push_held(KIND_FLOAT, 1'b1);
          end
        end
        SCAN_STRING: begin
          restart = 1'b0;
          if (c == CH_QUOTE) begin
            if (held_valid) push_held(KIND_STRING, 1'b1);
            else push_word(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1, tok_line, tok_col);
            mode       = SCAN_IDLE;
            held_valid = 1'b0;
          end else begin
            first = !held_valid;
            if (held_valid) push_held(KIND_STRING, 1'b0);
            hold_char(c, first);
          end
        end
        default: ;
      endcase

      // start a new token or skip white space
      if (restart) begin
        held_valid = 1'b0;
        mode       = SCAN_IDLE;
        if (c == CH_SPACE || c == CH_LF) begin
          // skipped
        end else if (is_letter(c) || is_digit(c)) begin
          mode     = is_letter(c) ? SCAN_IDENT : SCAN_INT;
          tok_line = ln;
          tok_col  = col;
          hold_char(c, 1'b1);
        end else if (c == CH_QUOTE) begin
          mode       = SCAN_STRING;
          tok_line   = ln;
          tok_col    = col;
          held_first = 1'b0;
        end else begin
          push_word(single_kind(c), c, 1'b1, 1'b1, 1'b1, ln, col);
        end
      end
      advance_position(c);
    end
    if (expected_words.size() > base) expected_words[$].run_end = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v, inout logic bad);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
      bad = 1'b1;
    end
  endtask

  // Compare one accepted token word with the oldest prediction
  task automatic check_word();
    token_word_t want;
    logic        bad;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected token word: expected none, got kind %0d char %h",
               $time, token_mon.token_kind, token_mon.token_char);
      fail_count_o++;
    end else begin
      want = expected_words.pop_front();
      bad  = 1'b0;
      check_field("token_kind", want.body.kind, token_mon.token_kind, bad);
      check_field("token_char", want.body.chr, token_mon.token_char, bad);
      check_field("has_char", want.body.has, token_mon.has_char, bad);
      check_field("token_first", want.body.first, token_mon.token_first, bad);
      check_field("token_last", want.body.last, token_mon.token_last, bad);
      check_field("start_line", want.body.line, token_mon.start_line, bad);
      check_field("start_column", want.body.col, token_mon.start_column, bad);
      check_field("run_end", want.run_end, token_mon.run_end, bad);
      if (bad) fail_count_o++;
    end
  endtask

  // Sample both channels on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_words.delete();
      mode            = SCAN_IDLE;
      held_char       = 8'h00;
      held_valid      = 1'b0;
      held_first      = 1'b0;
      line_no         = 16'd1;
      col_no          = 16'd1;
      tok_line        = 16'd1;
      tok_col         = 16'd1;
      fail_count_o    = 0;
      words_pending_o = 0;
    end else begin
      if (token_mon.valid && token_mon.ready) check_word();
      if (text_mon.valid && text_mon.ready) scan_byte(text_mon.char_code, text_mon.end_of_text);
      words_pending_o = expected_words.size();
    end
  end

endmodule

[sim/tb_source_text_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// Tokenizer core testbench
// Feeds the core a directed text, then random token streams with noise,
// then a short tail and finally an end of input. Both channels idle at
// random; a separate checker predicts and compares every token word.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer_core;
  import stt_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 1050;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic calm   = 1'b0;
  int   fail_count;
  int   words_pending;
  int   token_bytes = 0;
  int   idle_cycles = 0;

  stt_text_if  text_ch ();
  stt_token_if token_ch ();

  source_text_tokenizer_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_ch),
    .token_o (token_ch)
  );

  token_stream_checker token_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .text_mon        (text_ch),
    .token_mon       (token_ch),
    .fail_count_o    (fail_count),
    .words_pending_o (words_pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stall the token side at random, except in the calm stretch
  always @(negedge clk_i) begin
    token_ch.ready <= calm || ($urandom_range(99) >= 29);
  end

  // End the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("source_text_tokenizer_core test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one text word; entered and left at a falling edge
  task automatic send_byte(logic [7:0] c, logic eot);
    while (!calm && $urandom_range(99) < 29) begin
      text_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    text_ch.valid       <= 1'b1;
    text_ch.char_code   <= c;
    text_ch.end_of_text <= eot;
    @(posedge clk_i);
    while (!text_ch.ready) @(posedge clk_i);
    if (c != CH_SPACE && c != CH_LF) token_bytes++;
    @(negedge clk_i);
  endtask

  // Hold off the text side until every predicted word has come out
  task automatic drain_tokens();
    text_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (words_pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("A" + $urandom_range(25)) : 8'("a" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  // Any byte that can sit inside a string
  function automatic logic [7:0] rand_string_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255, 1));
    return (c == CH_QUOTE) ? 8'h5F : c;
  endfunction

  // One well-formed token with random content, or a noise byte
  task automatic send_random_token();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  punct;
    pick = $urandom_range(99);
    if (pick < 20) begin
      send_byte(rand_letter(), 1'b0);
      len = $urandom_range(6);
      repeat (len) send_byte($urandom_range(2) ? rand_letter() : rand_digit(), 1'b0);
    end else if (pick < 33) begin
      len = $urandom_range(5, 1);
      repeat (len) send_byte(rand_digit(), 1'b0);
    end else if (pick < 48) begin
      len = $urandom_range(4, 1);
      repeat (len) send_byte(rand_digit(), 1'b0);
      send_byte(CH_DOT, 1'b0);
      len = $urandom_range(4);
      repeat (len) send_byte(rand_digit(), 1'b0);
      // second dot closes the number
      if ($urandom_range(3) == 0) send_byte(CH_DOT, 1'b0);
    end else if (pick < 63) begin
      send_byte(CH_QUOTE, 1'b0);
      len = $urandom_range(6);
      repeat (len) send_byte(rand_string_byte(), 1'b0);
      send_byte(CH_QUOTE, 1'b0);
    end else if (pick < 85) begin
      case ($urandom_range(6))
        0:       punct = CH_EQ;
        1:       punct = CH_SEMI;
        2:       punct = CH_LPAREN;
        3:       punct = CH_RPAREN;
        4:       punct = CH_LBRACE;
        5:       punct = CH_RBRACE;
        default: punct = CH_COMMA;
      endcase
      send_byte(punct, 1'b0);
    end else begin
      send_byte(8'($urandom_range(255, 1)), 1'b0);
    end
  endtask

  // White space between tokens, often none
  task automatic send_random_gap();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(9);
    if (pick < 4) begin
      // adjacent tokens
    end else if (pick < 8) begin
      send_byte(CH_SPACE, 1'b0);
    end else if (pick < 9) begin
      send_byte(CH_LF, 1'b0);
    end else begin
      len = $urandom_range(3, 1);
      repeat (len) send_byte($urandom_range(1) ? CH_SPACE : CH_LF, 1'b0);
    end
  endtask

  logic [7:0] directed_text [26];
  logic       paused;

  initial begin
    directed_text = '{"A", "z", "9", CH_EQ, CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACE,
                      CH_RBRACE, CH_COMMA, "0", CH_DOT, "5", CH_DOT, CH_QUOTE, CH_QUOTE,
                      CH_QUOTE, "a", CH_QUOTE, "7", CH_DOT, CH_SPACE, 8'hFF, 8'h09,
                      CH_LF, 8'h01};
    paused               = 1'b0;
    text_ch.valid        = 1'b0;
    text_ch.char_code    = 8'h00;
    text_ch.end_of_text  = 1'b0;
    token_ch.ready       = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: field extremes, every kind but end of file and unterminated string, number and string corner cases
    foreach (directed_text[i]) send_byte(directed_text[i], 1'b0);
    drain_tokens();

    // random token streams, a calm stretch and one full drain in between
    token_bytes = 0;
    while (token_bytes < RANDOM_BYTES) begin
      calm = (token_bytes >= 500 && token_bytes < 800);
      send_random_token();
      send_random_gap();
      if (!paused && token_bytes >= 900) begin
        paused = 1'b1;
        drain_tokens();
      end
    end
    calm = 1'b0;
    send_byte(CH_LF, 1'b0);

    // short tail on a fresh line
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte(CH_SEMI, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte("q", 1'b0);
    send_byte(CH_SPACE, 1'b0);

    // end of input with a random token, or none, left open
    case ($urandom_range(5))
      0: ;
      1: send_byte("z", 1'b0);
      2: send_byte("5", 1'b0);
      3: begin
        send_byte("1", 1'b0);
        send_byte(CH_DOT, 1'b0);
      end
      4: begin
        send_byte(CH_QUOTE, 1'b0);
        send_byte("s", 1'b0);
      end
      default: send_byte(CH_QUOTE, 1'b0);
    endcase
    if ($urandom_range(1)) send_byte(8'($urandom_range(255)), 1'b1);
    else send_byte(CH_NUL, 1'b0);

    // input after the end is ignored
    send_byte(8'($urandom_range(255)), 1'b1);
    repeat (3) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));

    drain_tokens();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && words_pending == 0) begin
      $display("source_text_tokenizer_core test passed");
    end else begin
      $display("source_text_tokenizer_core test failed");
    end
    $finish;
  end

endmodule
